// File: src/kvi_pkg.sv
// kvi_pkg: shared types, codes and helpers for the keyframe interpolator
// used by kvi_ctrl, kvi_datapath and keyframe_vec3_interpolator_unit
// no dependencies
package kvi_pkg;

    // default parameter values
    localparam int KEY_DEPTH_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    // fixed widths
    localparam int DATA_W      = 32;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 66;
    localparam int ACC_W       = 72;
    localparam int IN_TDATA_W  = 328;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_DATA_W  = 7;

    // item opcodes (s_tuser)
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic REG_KEY_COUNT   = 1'b0;
    localparam logic REG_INTERP_MODE = 1'b1;

    // interpolation modes
    localparam logic [1:0] MODE_STEP    = 2'd0;
    localparam logic [1:0] MODE_LINEAR  = 2'd1;
    localparam logic [1:0] MODE_HERMITE = 2'd2;

    // multiplier operand a select
    localparam logic [3:0] ASEL_T    = 4'd0;
    localparam logic [3:0] ASEL_T2   = 4'd1;
    localparam logic [3:0] ASEL_DIFF = 4'd2;
    localparam logic [3:0] ASEL_TOUT = 4'd3;
    localparam logic [3:0] ASEL_TIN  = 4'd4;
    localparam logic [3:0] ASEL_H00  = 4'd5;
    localparam logic [3:0] ASEL_H01  = 4'd6;
    localparam logic [3:0] ASEL_H10  = 4'd7;
    localparam logic [3:0] ASEL_H11  = 4'd8;

    // multiplier operand b select
    localparam logic [2:0] BSEL_T    = 3'd0;
    localparam logic [2:0] BSEL_DT   = 3'd1;
    localparam logic [2:0] BSEL_P0   = 3'd2;
    localparam logic [2:0] BSEL_P1   = 3'd3;
    localparam logic [2:0] BSEL_M0LO = 3'd4;
    localparam logic [2:0] BSEL_M0HI = 3'd5;
    localparam logic [2:0] BSEL_M1LO = 3'd6;
    localparam logic [2:0] BSEL_M1HI = 3'd7;

    // product write-back actions
    localparam logic [3:0] WB_NONE    = 4'd0;
    localparam logic [3:0] WB_T2      = 4'd1;
    localparam logic [3:0] WB_T3      = 4'd2;
    localparam logic [3:0] WB_HBASIS  = 4'd3;
    localparam logic [3:0] WB_LIN     = 4'd4;
    localparam logic [3:0] WB_M0      = 4'd5;
    localparam logic [3:0] WB_M1      = 4'd6;
    localparam logic [3:0] WB_ACC_SET = 4'd7;
    localparam logic [3:0] WB_ACC_ADD = 4'd8;
    localparam logic [3:0] WB_ACC_HI  = 4'd9;
    localparam logic [3:0] WB_FINAL   = 4'd10;

    // micro programs
    localparam logic [1:0] PROG_PRE  = 2'd0;
    localparam logic [1:0] PROG_HERM = 2'd1;
    localparam logic [1:0] PROG_LIN  = 2'd2;

    // saturation bounds
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        $signed({{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF});
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000});

    // one keyframe table row
    typedef struct packed {
        logic [2:0][DATA_W-1:0] tout;
        logic [2:0][DATA_W-1:0] tin;
        logic [2:0][DATA_W-1:0] val;
        logic [DATA_W-1:0]      time_pt;
    } key_row_t;

    // one micro step: operand selects for this cycle, write-back of last product
    typedef struct packed {
        logic [3:0] a_sel;
        logic [2:0] b_sel;
        logic [3:0] wb;
        logic       last;
    } ucode_t;

    // controller to datapath commands
    typedef struct packed {
        logic       wr;
        logic       capture;
        logic       rd_en;
        logic       load_prev;
        logic       load_next;
        logic       div_init;
        logic       div_step;
        logic       res_zero;
        logic       res_direct;
        logic       uc_en;
        ucode_t     uc;
        logic [1:0] comp;
        logic       publish;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic rd_gt;
        logic rd_lt;
    } dp_stat_t;

    // micro program rom
    function automatic ucode_t ucode(input logic [1:0] prog, input logic [3:0] step);
        ucode_t u;
        u = '{a_sel: ASEL_T, b_sel: BSEL_T, wb: WB_NONE, last: 1'b0};
        case (prog)
            PROG_PRE:
            begin
                case (step)
                    4'd0: u = '{a_sel: ASEL_T,  b_sel: BSEL_T, wb: WB_NONE,   last: 1'b0};
                    4'd1: u = '{a_sel: ASEL_T,  b_sel: BSEL_T, wb: WB_T2,     last: 1'b0};
                    4'd2: u = '{a_sel: ASEL_T2, b_sel: BSEL_T, wb: WB_NONE,   last: 1'b0};
                    4'd3: u = '{a_sel: ASEL_T2, b_sel: BSEL_T, wb: WB_T3,     last: 1'b0};
                    default: u = '{a_sel: ASEL_T, b_sel: BSEL_T, wb: WB_HBASIS, last: 1'b1};
                endcase
            end
            PROG_HERM:
            begin
                case (step)
                    4'd0: u = '{a_sel: ASEL_TOUT, b_sel: BSEL_DT,   wb: WB_NONE,    last: 1'b0};
                    4'd1: u = '{a_sel: ASEL_TIN,  b_sel: BSEL_DT,   wb: WB_M0,      last: 1'b0};
                    4'd2: u = '{a_sel: ASEL_H00,  b_sel: BSEL_P0,   wb: WB_M1,      last: 1'b0};
                    4'd3: u = '{a_sel: ASEL_H01,  b_sel: BSEL_P1,   wb: WB_ACC_SET, last: 1'b0};
                    4'd4: u = '{a_sel: ASEL_H10,  b_sel: BSEL_M0LO, wb: WB_ACC_ADD, last: 1'b0};
                    4'd5: u = '{a_sel: ASEL_H10,  b_sel: BSEL_M0HI, wb: WB_ACC_ADD, last: 1'b0};
                    4'd6: u = '{a_sel: ASEL_H11,  b_sel: BSEL_M1LO, wb: WB_ACC_HI,  last: 1'b0};
                    4'd7: u = '{a_sel: ASEL_H11,  b_sel: BSEL_M1HI, wb: WB_ACC_ADD, last: 1'b0};
                    4'd8: u = '{a_sel: ASEL_T,    b_sel: BSEL_T,    wb: WB_ACC_HI,  last: 1'b0};
                    default: u = '{a_sel: ASEL_T, b_sel: BSEL_T,    wb: WB_FINAL,   last: 1'b1};
                endcase
            end
            default:
            begin
                case (step)
                    4'd0: u = '{a_sel: ASEL_DIFF, b_sel: BSEL_T, wb: WB_NONE, last: 1'b0};
                    default: u = '{a_sel: ASEL_T, b_sel: BSEL_T, wb: WB_LIN,  last: 1'b1};
                endcase
            end
        endcase
        return u;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v > SAT_MAX)
            r = 32'h7FFF_FFFF;
        else if (v < SAT_MIN)
            r = 32'h8000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// File: src/keyframe_vec3_interpolator_unit.sv
// keyframe_vec3_interpolator_unit: keyframe table with step, linear and hermite sampling
// write items go straight into the table; a sample on an empty table gives the zero vector;
// otherwise a key search (one table read per cycle); inside the key range a restoring divider
// follows, then in linear or hermite mode a micro program on the one shared 33x33 multiplier
// one item at a time; a new item is taken while the last result waits in the output register
// reset clears control state, key_count to 0 and interp_mode to linear; table undefined
module keyframe_vec3_interpolator_unit #(
    parameter int KEY_DEPTH = kvi_pkg::KEY_DEPTH_DEF,
    parameter int FRAC_BITS = kvi_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // key_index[5:0], time_point[37:6], value_x/y/z[133:38],
    // tan_in_x/y/z[229:134], tan_out_x/y/z[325:230], zero pad[327:326]
    input  logic [kvi_pkg::IN_TDATA_W-1:0]     s_tdata,
    // opcode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_x[31:0], result_y[63:32], result_z[95:64]
    output logic [kvi_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // table_empty
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [kvi_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(KEY_DEPTH);

    kvi_pkg::dp_cmd_t  cmd;
    kvi_pkg::dp_stat_t stat;
    logic [AW-1:0]     rd_addr;

    // controller
    kvi_ctrl #(
        .KEY_DEPTH (KEY_DEPTH),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    // datapath
    kvi_datapath #(
        .KEY_DEPTH (KEY_DEPTH),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_datapath (
        .clk     (clk),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // empty table result is the zero vector
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("empty table result not zero");

    // a sample item holds off the next item
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == kvi_pkg::OP_SAMPLE) |=> !s_tready)
        else $error("item accepted during sample");

endmodule

// File: src/kvi_ctrl.sv
// kvi_ctrl: controller for the keyframe interpolator
// holds configuration registers, key search, divider and micro program sequencing
// depends on kvi_pkg
module kvi_ctrl #(
    parameter int KEY_DEPTH = kvi_pkg::KEY_DEPTH_DEF,
    parameter int FRAC_BITS = kvi_pkg::FRAC_BITS_DEF,
    parameter int AW        = $clog2(KEY_DEPTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [kvi_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  kvi_pkg::dp_stat_t                 stat,
    output kvi_pkg::dp_cmd_t                  cmd,
    output logic [AW-1:0]                     rd_addr
);

    localparam int NW    = $clog2(KEY_DEPTH + 1);
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHK0   = 4'd1;
    localparam logic [3:0] ST_CHKL   = 4'd2;
    localparam logic [3:0] ST_SCAN0  = 4'd3;
    localparam logic [3:0] ST_SCAN   = 4'd4;
    localparam logic [3:0] ST_DIVI   = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_MUL    = 4'd7;
    localparam logic [3:0] ST_DIRECT = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [6:0]       key_count_reg;
    logic [1:0]       mode_reg;
    logic [NW-1:0]    n_reg, n_next;
    logic [NW-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       prog_reg, prog_next;
    logic [3:0]       step_reg, step_next;
    logic [1:0]       comp_reg, comp_next;
    logic             out_valid_reg, out_valid_next;
    logic [NW-1:0]    n_cur;
    logic [NW-1:0]    last_idx;
    kvi_pkg::ucode_t  uc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign uc        = kvi_pkg::ucode(prog_reg, step_reg);
    assign last_idx  = n_reg - NW'(1);

    // usable key count
    always_comb
    begin
        if (32'(key_count_reg) < 32'(KEY_DEPTH))
            n_cur = NW'(key_count_reg);
        else
            n_cur = NW'(KEY_DEPTH);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            mode_reg      <= kvi_pkg::MODE_LINEAR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == kvi_pkg::REG_KEY_COUNT)
                key_count_reg <= cfg_data;
            else
                mode_reg <= cfg_data[1:0];
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        prog_next      = prog_reg;
        step_next      = step_reg;
        comp_next      = comp_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        rd_addr        = '0;
        cmd            = '0;
        cmd.uc         = uc;
        cmd.comp       = comp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == kvi_pkg::OP_WRITE)
                        cmd.wr = 1'b1;
                    else
                    begin
                        cmd.capture = 1'b1;
                        n_next      = n_cur;
                        if (n_cur == '0)
                        begin
                            cmd.res_zero = 1'b1;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = ST_CHK0;
                        end
                    end
                end
            end
            ST_CHK0:
            begin
                if (n_reg == NW'(1) || !stat.rd_lt)
                begin
                    cmd.load_prev = 1'b1;
                    state_next    = ST_DIRECT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = last_idx[AW-1:0];
                    state_next = ST_CHKL;
                end
            end
            ST_CHKL:
            begin
                if (!stat.rd_gt)
                begin
                    cmd.load_prev = 1'b1;
                    state_next    = ST_DIRECT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SCAN0;
                end
            end
            ST_SCAN0:
            begin
                cmd.load_prev = 1'b1;
                cmd.rd_en     = 1'b1;
                idx_next      = NW'(1);
                rd_addr       = idx_next[AW-1:0];
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // first key later than the query time ends the scan
                if (stat.rd_gt)
                begin
                    cmd.load_next = 1'b1;
                    state_next    = ST_DIVI;
                end
                else
                begin
                    cmd.load_prev = 1'b1;
                    cmd.rd_en     = 1'b1;
                    idx_next      = idx_reg + NW'(1);
                    rd_addr       = idx_next[AW-1:0];
                end
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_BITS - 1))
                begin
                    step_next = '0;
                    comp_next = '0;
                    if (mode_reg == kvi_pkg::MODE_STEP)
                        state_next = ST_DIRECT;
                    else if (mode_reg == kvi_pkg::MODE_HERMITE)
                    begin
                        prog_next  = kvi_pkg::PROG_PRE;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        prog_next  = kvi_pkg::PROG_LIN;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.uc_en = 1'b1;
                if (uc.last)
                begin
                    step_next = '0;
                    if (prog_reg == kvi_pkg::PROG_PRE)
                        prog_next = kvi_pkg::PROG_HERM;
                    else if (comp_reg == 2'd2)
                        state_next = ST_DONE;
                    else
                        comp_next = comp_reg + 2'd1;
                end
                else
                    step_next = step_reg + 4'd1;
            end
            ST_DIRECT:
            begin
                cmd.res_direct = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            prog_reg      <= kvi_pkg::PROG_PRE;
            step_reg      <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            prog_reg      <= prog_next;
            step_reg      <= step_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/kvi_datapath.sv
// kvi_datapath: key table memory, divider, shared multiplier and result registers
// driven by kvi_ctrl through dp_cmd_t
// depends on kvi_pkg
module kvi_datapath #(
    parameter int KEY_DEPTH = kvi_pkg::KEY_DEPTH_DEF,
    parameter int FRAC_BITS = kvi_pkg::FRAC_BITS_DEF,
    parameter int AW        = $clog2(KEY_DEPTH)
) (
    input  logic                               clk,
    input  logic [kvi_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  kvi_pkg::dp_cmd_t                   cmd,
    input  logic [AW-1:0]                      rd_addr,
    output kvi_pkg::dp_stat_t                  stat,
    output logic [kvi_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tuser
);

    localparam int HW = FRAC_BITS + 3;
    localparam int MW = kvi_pkg::MUL_W;
    localparam int PW = kvi_pkg::PROD_W;
    localparam int CW = kvi_pkg::ACC_W;

    kvi_pkg::key_row_t mem [KEY_DEPTH];
    kvi_pkg::key_row_t wr_row;
    kvi_pkg::key_row_t rd_row_reg, prev_reg, next_reg;

    logic [5:0]                 key_index;
    logic                       wr_ok;
    logic [31:0]                tq_reg;
    logic [31:0]                dt_reg;
    logic [31:0]                rem_reg;
    logic [32:0]                rem_dbl;
    logic [FRAC_BITS-1:0]       t_reg, t2_reg, t3_reg;
    logic signed [HW-1:0]       h00_reg, h10_reg, h01_reg, h11_reg;
    logic signed [HW-1:0]       t_s, t2_s, t3_s, one_s;
    logic signed [MW-1:0]       mul_a, mul_b;
    logic signed [PW-1:0]       prod_reg, prod_sh;
    logic signed [PW-1:0]       m0_reg, m1_reg;
    logic signed [CW-1:0]       acc_reg, acc_sh;
    logic [2:0][31:0]           res_reg;
    logic                       empty_reg;
    logic [31:0]                p0, p1, tout, tin;

    // input item unpacking
    assign key_index      = s_tdata[5:0];
    assign wr_row.time_pt = s_tdata[37:6];
    assign wr_row.val     = s_tdata[133:38];
    assign wr_row.tin     = s_tdata[229:134];
    assign wr_row.tout    = s_tdata[325:230];
    assign wr_ok          = 32'(key_index) < 32'(KEY_DEPTH);

    // key table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr && wr_ok)
            mem[AW'(key_index)] <= wr_row;
        if (cmd.rd_en)
            rd_row_reg <= mem[rd_addr];
    end

    assign stat.rd_gt = rd_row_reg.time_pt > tq_reg;
    assign stat.rd_lt = rd_row_reg.time_pt < tq_reg;

    // operands of the current component
    assign p0   = prev_reg.val[cmd.comp];
    assign p1   = next_reg.val[cmd.comp];
    assign tout = prev_reg.tout[cmd.comp];
    assign tin  = next_reg.tin[cmd.comp];

    // restoring divider step
    assign rem_dbl = {rem_reg, 1'b0};

    // hermite basis from t, t^2, t^3
    assign t_s   = HW'(t_reg);
    assign t2_s  = HW'(t2_reg);
    assign t3_s  = HW'(t3_reg);
    assign one_s = {3'b001, {FRAC_BITS{1'b0}}};

    // multiplier operand a
    always_comb
    begin
        case (cmd.uc.a_sel)
            kvi_pkg::ASEL_T:    mul_a = MW'(t_s);
            kvi_pkg::ASEL_T2:   mul_a = MW'(t2_s);
            kvi_pkg::ASEL_DIFF: mul_a = $signed({p1[31], p1}) - $signed({p0[31], p0});
            kvi_pkg::ASEL_TOUT: mul_a = MW'($signed(tout));
            kvi_pkg::ASEL_TIN:  mul_a = MW'($signed(tin));
            kvi_pkg::ASEL_H00:  mul_a = MW'(h00_reg);
            kvi_pkg::ASEL_H01:  mul_a = MW'(h01_reg);
            kvi_pkg::ASEL_H10:  mul_a = MW'(h10_reg);
            kvi_pkg::ASEL_H11:  mul_a = MW'(h11_reg);
            default:            mul_a = '0;
        endcase
    end

    // multiplier operand b
    always_comb
    begin
        case (cmd.uc.b_sel)
            kvi_pkg::BSEL_T:    mul_b = MW'(t_s);
            kvi_pkg::BSEL_DT:   mul_b = $signed({1'b0, dt_reg});
            kvi_pkg::BSEL_P0:   mul_b = MW'($signed(p0));
            kvi_pkg::BSEL_P1:   mul_b = MW'($signed(p1));
            kvi_pkg::BSEL_M0LO: mul_b = $signed({1'b0, m0_reg[31:0]});
            kvi_pkg::BSEL_M0HI: mul_b = m0_reg[64:32];
            kvi_pkg::BSEL_M1LO: mul_b = $signed({1'b0, m1_reg[31:0]});
            default:            mul_b = m1_reg[64:32];
        endcase
    end

    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign acc_sh  = acc_reg >>> FRAC_BITS;

    // search rows, divider and query capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            tq_reg <= s_tdata[37:6];
        if (cmd.load_prev)
            prev_reg <= rd_row_reg;
        if (cmd.load_next)
            next_reg <= rd_row_reg;
        if (cmd.div_init)
        begin
            dt_reg  <= next_reg.time_pt - prev_reg.time_pt;
            rem_reg <= tq_reg - prev_reg.time_pt;
            t_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_dbl >= {1'b0, dt_reg})
            begin
                rem_reg <= 32'(rem_dbl - {1'b0, dt_reg});
                t_reg   <= {t_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_dbl[31:0];
                t_reg   <= {t_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    // shared multiplier and product write-back
    always_ff @(posedge clk)
    begin
        if (cmd.uc_en)
        begin
            prod_reg <= mul_a * mul_b;
            case (cmd.uc.wb)
                kvi_pkg::WB_T2:      t2_reg <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
                kvi_pkg::WB_T3:      t3_reg <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
                kvi_pkg::WB_HBASIS:
                begin
                    h00_reg <= (t3_s <<< 1) - (t2_s <<< 1) - t2_s + one_s;
                    h10_reg <= t3_s - (t2_s <<< 1) + t_s;
                    h01_reg <= (t2_s <<< 1) + t2_s - (t3_s <<< 1);
                    h11_reg <= t3_s - t2_s;
                end
                kvi_pkg::WB_M0:      m0_reg <= prod_sh;
                kvi_pkg::WB_M1:      m1_reg <= prod_sh;
                kvi_pkg::WB_ACC_SET: acc_reg <= CW'(prod_reg);
                kvi_pkg::WB_ACC_ADD: acc_reg <= acc_reg + CW'(prod_reg);
                kvi_pkg::WB_ACC_HI:  acc_reg <= acc_reg + (CW'(prod_reg) <<< 32);
                default:
                begin
                end
            endcase
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture && !cmd.res_zero)
            empty_reg <= 1'b0;
        if (cmd.res_zero)
        begin
            res_reg   <= '0;
            empty_reg <= 1'b1;
        end
        else if (cmd.res_direct)
            res_reg <= prev_reg.val;
        else if (cmd.uc_en && cmd.uc.wb == kvi_pkg::WB_LIN)
            res_reg[cmd.comp] <= kvi_pkg::sat32(CW'($signed(p0)) + CW'(prod_sh));
        else if (cmd.uc_en && cmd.uc.wb == kvi_pkg::WB_FINAL)
            res_reg[cmd.comp] <= kvi_pkg::sat32(acc_sh);
    end

    // output register, parts the work from the consumer
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            m_tdata <= res_reg;
            m_tuser <= empty_reg;
        end
    end

endmodule

// File: test/tb_top.sv
// tb_top: self-checking testbench for keyframe_vec3_interpolator_unit
// drives keyframe writes and samples, predicts each sampled vector and compares it
// depends on kvi_pkg and keyframe_vec3_interpolator_unit
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_ITEMS   = 1700;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_REPORTS = 10;

    typedef logic signed [127:0] wide_t;

    // one input item as the driver sees it
    typedef struct packed {
        logic             op;
        logic [5:0]       idx;
        logic [31:0]      tp;
        logic [2:0][31:0] val;
        logic [2:0][31:0] tin;
        logic [2:0][31:0] tout;
    } key_item_t;

    // one sampled vector
    typedef struct packed {
        logic             empty;
        logic [2:0][31:0] vec;
    } sample_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [kvi_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [kvi_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [kvi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // stimulus and scoreboard state
    key_item_t   pending_items[$];
    sample_res_t expected_vecs[$];
    key_item_t   cur_item = '0;
    logic        item_taken = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;
    bit          src_idle_en = 1'b0;
    bit          sink_idle_en = 1'b0;
    int          mismatches = 0;
    int          cycles = 0;
    int          queued = 0;

    // predictor copy of the key table and registers
    logic [31:0]        tbl_time[64];
    logic signed [31:0] tbl_val[64][3];
    logic signed [31:0] tbl_tin[64][3];
    logic signed [31:0] tbl_tout[64][3];
    logic [6:0]         keys_valid = 7'd0;
    logic [1:0]         mode_reg = kvi_pkg::MODE_LINEAR;

    // generator view of key times
    logic [31:0] gen_time[64];

    keyframe_vec3_interpolator_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] clamp32(input wide_t v);
        logic [31:0] r;
        if (v > wide_t'(32'sh7FFF_FFFF))
            r = 32'h7FFF_FFFF;
        else if (v < -wide_t'(33'sh0_8000_0000))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // cubic hermite blend with tangents scaled by the key interval
    function automatic wide_t hermite_blend(input wide_t p0, input wide_t p1, input wide_t mo,
                                            input wide_t mi, input wide_t dt, input wide_t t);
        wide_t one, t2, t3, h00, h10, h01, h11, m0, m1, sum;
        one = 65536;
        t2  = (t * t) >>> 16;
        t3  = (t2 * t) >>> 16;
        h00 = 2 * t3 - 3 * t2 + one;
        h10 = t3 - 2 * t2 + t;
        h01 = -2 * t3 + 3 * t2;
        h11 = t3 - t2;
        m0  = (mo * dt) >>> 16;
        m1  = (mi * dt) >>> 16;
        sum = h00 * p0 + h10 * m0 + h01 * p1 + h11 * m1;
        return sum >>> 16;
    endfunction

    // expected vector for a sample at query time tq
    function automatic sample_res_t sample_vector(input logic [31:0] tq);
        sample_res_t r;
        int          n, nx, pv;
        logic [63:0] dt64, t64;
        wide_t       p0, p1, dtw, tw, acc;
        r = '0;
        n = (keys_valid > 7'd64) ? 64 : int'(keys_valid);
        if (n == 0)
        begin
            r.empty = 1'b1;
            return r;
        end
        if (n == 1 || tq <= tbl_time[0])
        begin
            for (int k = 0; k < 3; k++)
                r.vec[k] = tbl_val[0][k];
            return r;
        end
        if (tq >= tbl_time[n-1])
        begin
            for (int k = 0; k < 3; k++)
                r.vec[k] = tbl_val[n-1][k];
            return r;
        end
        // first key later than the query, previous one before it
        nx = n - 1;
        for (int i = n - 1; i >= 1; i--)
            if (tbl_time[i] > tq)
                nx = i;
        pv   = nx - 1;
        dt64 = {32'd0, tbl_time[nx]} - {32'd0, tbl_time[pv]};
        t64  = ({32'd0, tq - tbl_time[pv]} << 16) / dt64;
        dtw  = wide_t'(dt64);
        tw   = wide_t'(t64);
        for (int k = 0; k < 3; k++)
        begin
            p0 = tbl_val[pv][k];
            p1 = tbl_val[nx][k];
            if (mode_reg == kvi_pkg::MODE_STEP)
                acc = p0;
            else if (mode_reg == kvi_pkg::MODE_HERMITE)
                acc = hermite_blend(p0, p1, wide_t'(tbl_tout[pv][k]),
                                    wide_t'(tbl_tin[nx][k]), dtw, tw);
            else
                acc = p0 + (((p1 - p0) * tw) >>> 16);
            r.vec[k] = clamp32(acc);
        end
        return r;
    endfunction

    // input item driver, fed from the pending queue
    always @(negedge clk)
    begin
        if (!s_tvalid || item_taken)
        begin
            if (src_gap > 0)
            begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (src_idle_en && $urandom_range(0, 9) == 0)
            begin
                src_gap  <= $urandom_range(0, 12);
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                cur_item <= pending_items[0];
                s_tdata  <= {2'b00, pending_items[0].tout, pending_items[0].tin,
                             pending_items[0].val, pending_items[0].tp, pending_items[0].idx};
                s_tuser  <= pending_items[0].op;
                s_tvalid <= 1'b1;
                void'(pending_items.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result backpressure
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 5) == 0)
        begin
            sink_gap <= $urandom_range(0, 12);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // accepted items update the table or queue an expected vector; results are checked
    always @(posedge clk)
    begin
        sample_res_t want;
        logic        bad;
        item_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            if (cur_item.op == kvi_pkg::OP_WRITE)
            begin
                tbl_time[cur_item.idx] = cur_item.tp;
                for (int k = 0; k < 3; k++)
                begin
                    tbl_val[cur_item.idx][k]  = cur_item.val[k];
                    tbl_tin[cur_item.idx][k]  = cur_item.tin[k];
                    tbl_tout[cur_item.idx][k] = cur_item.tout[k];
                end
            end
            else
                expected_vecs.insert(expected_vecs.size(), sample_vector(cur_item.tp));
        end
        if (m_tvalid && m_tready)
        begin
            if (expected_vecs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: tdata=%h empty=%b", m_tdata, m_tuser);
            end
            else
            begin
                want = expected_vecs.pop_front();
                bad  = (m_tuser !== want.empty);
                for (int k = 0; k < 3; k++)
                    if (m_tdata[32*k +: 32] !== want.vec[k])
                        bad = 1'b1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected x=%h y=%h z=%h empty=%b, ",
                                  "got x=%h y=%h z=%h empty=%b"},
                                 want.vec[0], want.vec[1], want.vec[2], want.empty,
                                 m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser);
                end
            end
        end
    end

    // mostly moderate values, sometimes extremes or full range
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 3))
                   0: v = 32'h7FFF_FFFF;
                   1: v = 32'h8000_0000;
                   2: v = 32'h0000_0000;
                   default: v = 32'hFFFF_FFFF;
               endcase
            1: v = $urandom;
            default: v = $unsigned($signed($urandom) >>> 10);
        endcase
        return v;
    endfunction

    task automatic push_write(input logic [5:0] idx, input logic [31:0] tp);
        key_item_t it;
        it.op  = kvi_pkg::OP_WRITE;
        it.idx = idx;
        it.tp  = tp;
        for (int k = 0; k < 3; k++)
        begin
            it.val[k]  = pick_value();
            it.tin[k]  = pick_value();
            it.tout[k] = pick_value();
        end
        gen_time[idx] = tp;
        pending_items.insert(pending_items.size(), it);
        queued++;
    endtask

    task automatic push_sample(input logic [31:0] tp);
        key_item_t    it;
        logic [351:0] noise;
        noise  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
        it     = noise[$bits(key_item_t)-1:0];
        it.op  = kvi_pkg::OP_SAMPLE;
        it.tp  = tp;
        pending_items.insert(pending_items.size(), it);
        queued++;
    endtask

    task automatic write_reg(input logic idx, input logic [kvi_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == kvi_pkg::REG_KEY_COUNT)
            keys_valid = data;
        else
            mode_reg = data[1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // all items taken and all results back, then let a trailing write settle
    task automatic wait_drained();
        @(posedge clk);
        while (pending_items.size() > 0 || s_tvalid || expected_vecs.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // load n keys with ascending or scattered times
    task automatic load_keys(input int n, input bit ordered);
        logic [31:0] tp;
        tp = $urandom_range(0, 1 << 20);
        for (int i = 0; i < n; i++)
        begin
            if (!ordered)
                tp = $urandom;
            else if (i > 0)
                case ($urandom_range(0, 3))
                    0: tp = tp + $urandom_range(1, 4);
                    1: tp = tp + $urandom_range(1, 1 << 24);
                    default: tp = tp + $urandom_range(1, 1 << 18);
                endcase
            push_write(i[5:0], tp);
        end
    endtask

    // query time, mostly near the keys of a table of n entries, sometimes an extreme or random time
    function automatic logic [31:0] pick_query(input int n);
        int          j;
        logic [31:0] lo, hi;
        j = $urandom_range(0, (n > 64 ? 64 : n) - 1);
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3: return gen_time[j];
            4: return gen_time[j] + 32'd1;
            5: return gen_time[j] - 32'd1;
            default:
            begin
                lo = gen_time[j];
                hi = (j + 1 < n && j < 63) ? gen_time[j+1] : lo;
                if (hi > lo + 32'd1)
                    return lo + 32'($urandom % (hi - lo));
                return lo;
            end
        endcase
    endfunction

    initial
    begin
        int          n, kc, cnt;
        logic [31:0] dir_times[4];
        logic [1:0]  mode;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table
        write_reg(kvi_pkg::REG_KEY_COUNT, 7'd0);
        write_reg(kvi_pkg::REG_INTERP_MODE, 7'(kvi_pkg::MODE_LINEAR));
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);
        wait_drained();

        // four keys: extreme values and tangents, a one-tick interval, last key at max time
        dir_times = '{32'h0001_0000, 32'h0003_0000, 32'h0003_0001, 32'hFFFF_FFFF};
        for (int i = 0; i < 4; i++)
        begin
            key_item_t it;
            it.op  = kvi_pkg::OP_WRITE;
            it.idx = i[5:0];
            it.tp  = dir_times[i];
            for (int k = 0; k < 3; k++)
            begin
                it.val[k]  = (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                it.tin[k]  = (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                it.tout[k] = (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            gen_time[i] = dir_times[i];
            pending_items.insert(pending_items.size(), it);
            queued++;
        end
        wait_drained();

        // single key
        write_reg(kvi_pkg::REG_KEY_COUNT, 7'd1);
        write_reg(kvi_pkg::REG_INTERP_MODE, 7'(kvi_pkg::MODE_HERMITE));
        push_sample(32'hFFFF_FFFF);
        wait_drained();

        // every mode, including the unused code, before, inside and on the keys
        write_reg(kvi_pkg::REG_KEY_COUNT, 7'd4);
        for (int m = 0; m < 4; m++)
        begin
            write_reg(kvi_pkg::REG_INTERP_MODE, 7'(m));
            push_sample(32'h0000_0000);
            push_sample(32'h0002_0000);
            push_sample(32'h8000_0000);
            push_sample(32'hFFFF_FFFF);
            wait_drained();
        end

        // random phases: reconfigure while drained, reload, then sample with noise writes
        while (queued < NUM_ITEMS)
        begin
            bit quiet;
            quiet        = (queued > NUM_ITEMS - 200);
            src_idle_en  = !quiet && ($urandom_range(0, 3) != 0);
            sink_idle_en = !quiet && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 19))
                0: n = 0;
                1: n = 1;
                2: n = 64;
                3, 4: n = $urandom_range(9, 63);
                default: n = $urandom_range(2, 8);
            endcase
            kc   = (n == 64 && $urandom_range(0, 1)) ? $urandom_range(64, 127) : n;
            mode = 2'($urandom_range(0, 3));
            write_reg(kvi_pkg::REG_KEY_COUNT, kc[6:0]);
            write_reg(kvi_pkg::REG_INTERP_MODE, 7'(mode));
            if (n > 0)
                load_keys(n, $urandom_range(0, 6) != 0);
            cnt = $urandom_range(8, 30);
            for (int s = 0; s < cnt; s++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_write(6'($urandom_range(0, 63)), $urandom);
                push_sample(n > 0 ? pick_query(n) : $urandom);
            end
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_vecs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
